// ===== rtl/complex_fir_filter_unit_assert.svh =====
// Assertion macros for the complex FIR filter RTL.
`ifndef COMPLEX_FIR_FILTER_UNIT_ASSERT_SVH
`define COMPLEX_FIR_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFIR_ASSERT_IMM(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cfir assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cfir assertion failed");

`endif

// ===== rtl/cfir_pkg.sv =====
// Types, constants and codes shared by the complex FIR filter modules.
package cfir_pkg;

	localparam int MAX_TAPS = 64;
	localparam int ADDR_W   = 6;
	localparam int NT_W     = 7;
	localparam int SAMPLE_W = 16;
	localparam int TAP_W    = 16;
	localparam int FRAC_W   = TAP_W - 1;
	localparam int PROD_W   = SAMPLE_W + TAP_W;
	localparam int ACC_W    = 40;

	localparam logic [1:0] MODE_FILTER = 2'd0;
	localparam logic [1:0] MODE_TAP    = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [PROD_W:0] psum_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] re;
		logic [SAMPLE_W-1:0] im;
	} cplx_t;

	// Control that travels along the multiply-accumulate pipeline.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic use_x0;
	} mac_ctrl_t;

endpackage

// ===== rtl/cfir_store.sv =====
// Complex-word memory with one write port, one registered read port and per-entry valid bits.
module cfir_store (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  cfir_pkg::addr_t wr_addr,
	input  cfir_pkg::cplx_t wr_data,
	input  logic            clr,
	input  cfir_pkg::addr_t rd_addr,
	output cfir_pkg::cplx_t rd_data
);

	cfir_pkg::cplx_t mem [cfir_pkg::MAX_TAPS];
	logic [cfir_pkg::MAX_TAPS-1:0] vld_q;
	cfir_pkg::cplx_t rd_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// An entry that was never written since reset or the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/cfir_mac.sv =====
// Complex multiply-accumulate pipeline with rounding and saturation of the final sum.
module cfir_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfir_pkg::mac_ctrl_t           ctrl,
	input  cfir_pkg::cplx_t               x0,
	input  cfir_pkg::cplx_t               hist,
	input  cfir_pkg::cplx_t               coef,
	output logic                          res_valid,
	output logic [cfir_pkg::SAMPLE_W-1:0] res_re,
	output logic [cfir_pkg::SAMPLE_W-1:0] res_im,
	output logic                          res_sat
);

	cfir_pkg::mac_ctrl_t ctrl_s1, ctrl_s2, ctrl_s3;
	cfir_pkg::cplx_t x;
	cfir_pkg::prod_t p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	cfir_pkg::psum_t sum_re, sum_im;
	cfir_pkg::acc_t acc_re_q, acc_im_q;
	cfir_pkg::acc_t rnd_re, rnd_im;
	logic [cfir_pkg::SAMPLE_W-1:0] fin_re, fin_im;
	logic clip_re, clip_im;
	logic res_valid_q;
	logic [cfir_pkg::SAMPLE_W-1:0] res_re_q, res_im_q;
	logic res_sat_q;

	// The bits above the result must all match its sign bit, else the value is clipped.
	function automatic logic [cfir_pkg::SAMPLE_W:0] sat_word(input cfir_pkg::acc_t r);
		logic [cfir_pkg::ACC_W-cfir_pkg::FRAC_W-cfir_pkg::SAMPLE_W:0] top;
		logic fits;
		top  = r[cfir_pkg::ACC_W-1:cfir_pkg::FRAC_W+cfir_pkg::SAMPLE_W-1];
		fits = (top == '0) || (top == '1);
		if (fits) begin
			sat_word = {1'b0, r[cfir_pkg::FRAC_W+cfir_pkg::SAMPLE_W-1:cfir_pkg::FRAC_W]};
		end else if (r[cfir_pkg::ACC_W-1]) begin
			sat_word = {1'b1, 1'b1, {(cfir_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			sat_word = {1'b1, 1'b0, {(cfir_pkg::SAMPLE_W-1){1'b1}}};
		end
	endfunction

	// The newest sample comes straight from the input register, not from the history memory.
	assign x = ctrl_s1.use_x0 ? x0 : hist;

	always_ff @(posedge clk) begin
		p_rr_s2 <= cfir_pkg::prod_t'($signed(x.re)) * cfir_pkg::prod_t'($signed(coef.re));
		p_ii_s2 <= cfir_pkg::prod_t'($signed(x.im)) * cfir_pkg::prod_t'($signed(coef.im));
		p_ri_s2 <= cfir_pkg::prod_t'($signed(x.re)) * cfir_pkg::prod_t'($signed(coef.im));
		p_ir_s2 <= cfir_pkg::prod_t'($signed(x.im)) * cfir_pkg::prod_t'($signed(coef.re));
	end

	assign sum_re = cfir_pkg::psum_t'(p_rr_s2) - cfir_pkg::psum_t'(p_ii_s2);
	assign sum_im = cfir_pkg::psum_t'(p_ri_s2) + cfir_pkg::psum_t'(p_ir_s2);

	always_ff @(posedge clk) begin
		if (ctrl_s2.valid) begin
			if (ctrl_s2.first) begin
				acc_re_q <= cfir_pkg::acc_t'(sum_re);
				acc_im_q <= cfir_pkg::acc_t'(sum_im);
			end else begin
				acc_re_q <= acc_re_q + cfir_pkg::acc_t'(sum_re);
				acc_im_q <= acc_im_q + cfir_pkg::acc_t'(sum_im);
			end
		end
	end

	assign rnd_re = acc_re_q + (cfir_pkg::acc_t'(1) <<< (cfir_pkg::FRAC_W - 1));
	assign rnd_im = acc_im_q + (cfir_pkg::acc_t'(1) <<< (cfir_pkg::FRAC_W - 1));
	assign {clip_re, fin_re} = sat_word(rnd_re);
	assign {clip_im, fin_im} = sat_word(rnd_im);

	// The result registers hold until the next item finishes.
	always_ff @(posedge clk) begin
		if (ctrl_s3.valid && ctrl_s3.last) begin
			res_re_q  <= fin_re;
			res_im_q  <= fin_im;
			res_sat_q <= clip_re | clip_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1     <= '0;
			ctrl_s2     <= '0;
			ctrl_s3     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			ctrl_s1     <= ctrl;
			ctrl_s2     <= ctrl_s1;
			ctrl_s3     <= ctrl_s2;
			res_valid_q <= ctrl_s3.valid & ctrl_s3.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_re    = res_re_q;
	assign res_im    = res_im_q;
	assign res_sat   = res_sat_q;

endmodule

// ===== rtl/complex_fir_filter_unit.sv =====
// A filter word steps the single complex MAC through the taps in use in the tap and history memories,
// one tap per cycle; the sums then pass the product, accumulator and result registers of the MAC and
// the output register to m_tdata. Tap writes and history clears are taken in the idle state without leaving it.
// A finished result waits in the output register while the next word is taken and worked on.
// Reset (arst_n low, asynchronous) zeroes history and taps through valid bits and sets num_taps to 1.
`include "complex_fir_filter_unit_assert.svh"

module complex_fir_filter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // sample_re, sample_im, tap_index, tap_re, tap_im, zero fill
	input  logic [1:0]  s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_re, out_im
	output logic        m_tuser,  // saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data  // num_taps
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_PUSH  = 4'b1000
	} state_t;

	state_t state_q;
	logic [cfir_pkg::NT_W-1:0] num_taps_q, n_eff, d_full;
	cfir_pkg::addr_t k_q, head_q, hist_rd_addr;
	cfir_pkg::cplx_t x0_q, in_sample, in_tap, hist_rd, coef_rd;
	cfir_pkg::addr_t in_tap_index;
	logic [1:0] in_mode;
	logic accept, issue_last, load_out;
	cfir_pkg::mac_ctrl_t ctrl;
	logic res_valid, res_sat;
	logic [cfir_pkg::SAMPLE_W-1:0] res_re, res_im;
	logic out_full_q, out_sat_q;
	logic [cfir_pkg::SAMPLE_W-1:0] out_re_q, out_im_q;

	assign in_mode      = s_tuser;
	assign in_sample    = {s_tdata[15:0], s_tdata[31:16]};
	assign in_tap_index = s_tdata[37:32];
	assign in_tap       = {s_tdata[53:38], s_tdata[69:54]};

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;

	// Zero taps counts as one, anything beyond the store depth as the depth.
	always_comb begin
		if (num_taps_q == '0) begin
			n_eff = cfir_pkg::NT_W'(1);
		end else if (num_taps_q > cfir_pkg::NT_W'(cfir_pkg::MAX_TAPS)) begin
			n_eff = cfir_pkg::NT_W'(cfir_pkg::MAX_TAPS);
		end else begin
			n_eff = num_taps_q;
		end
	end

	// Tap k weights the sample d = n-1-k steps back; the ring pointer already moved past the newest one.
	assign d_full       = n_eff - cfir_pkg::NT_W'(1) - {1'b0, k_q};
	assign hist_rd_addr = head_q - d_full[cfir_pkg::ADDR_W-1:0] - cfir_pkg::addr_t'(1);
	assign issue_last   = ({1'b0, k_q} == (n_eff - cfir_pkg::NT_W'(1)));

	always_comb begin
		ctrl.valid  = (state_q == ST_RUN);
		ctrl.first  = (k_q == '0);
		ctrl.last   = issue_last;
		ctrl.use_x0 = (d_full == '0);
	end

	cfir_store u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && in_mode == cfir_pkg::MODE_FILTER),
		.wr_addr (head_q),
		.wr_data (in_sample),
		.clr     (accept && in_mode == cfir_pkg::MODE_CLEAR),
		.rd_addr (hist_rd_addr),
		.rd_data (hist_rd)
	);

	cfir_store u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && in_mode == cfir_pkg::MODE_TAP),
		.wr_addr (in_tap_index),
		.wr_data (in_tap),
		.clr     (1'b0),
		.rd_addr (k_q),
		.rd_data (coef_rd)
	);

	cfir_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.x0        (x0_q),
		.hist      (hist_rd),
		.coef      (coef_rd),
		.res_valid (res_valid),
		.res_re    (res_re),
		.res_im    (res_im),
		.res_sat   (res_sat)
	);

	assign load_out = ((state_q == ST_DRAIN && res_valid) || state_q == ST_PUSH)
		&& (!out_full_q || m_tready);

	always_ff @(posedge clk) begin
		if (accept && in_mode == cfir_pkg::MODE_FILTER) begin
			x0_q <= in_sample;
		end
		if (load_out) begin
			out_re_q  <= res_re;
			out_im_q  <= res_im;
			out_sat_q <= res_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			num_taps_q <= cfir_pkg::NT_W'(1);
			k_q        <= '0;
			head_q     <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_taps_q <= cfg_data;
			end
			if (load_out) begin
				out_full_q <= 1'b1;
			end else if (m_tready) begin
				out_full_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept && in_mode == cfir_pkg::MODE_FILTER) begin
						head_q  <= head_q + cfir_pkg::addr_t'(1);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					k_q <= k_q + cfir_pkg::addr_t'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (res_valid) begin
						state_q <= load_out ? ST_IDLE : ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_full_q;
	assign m_tdata  = {out_im_q, out_re_q};
	assign m_tuser  = out_sat_q;

	`CFIR_ASSERT_IMM(a_res_only_in_drain, clk, arst_n, res_valid, state_q == ST_DRAIN)
	`CFIR_ASSERT_IMM(a_tap_counter_in_range, clk, arst_n, state_q == ST_RUN, ({1'b0, k_q} < n_eff))
	`CFIR_ASSERT_IMM(a_out_loaded_after_mac, clk, arst_n, $rose(m_tvalid),
		$past(state_q == ST_DRAIN) || $past(state_q == ST_PUSH))

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the complex FIR filter unit, checked against a built-in predictor.
module testbench;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 45;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_TAPS [NUM_PHASES] = '{2, 0, 64, 5, 127, 1, 65, 3, 16, 8};

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               sat;
	} fir_out_t;

	typedef struct {
		logic [1:0] mode;
		int         re;
		int         im;
		int         idx;
		bit         typed;
		int         e_re;
		int         e_im;
		bit         e_sat;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;

	fir_out_t fir_expected[$];
	shortint  hist_re [0:cfir_pkg::MAX_TAPS-2];
	shortint  hist_im [0:cfir_pkg::MAX_TAPS-2];
	shortint  coef_re [0:cfir_pkg::MAX_TAPS-1];
	shortint  coef_im [0:cfir_pkg::MAX_TAPS-1];
	int       tap_count;
	int       err_count = 0;
	int       cycle_count = 0;
	int       hold_ticket = 0;
	bit       src_idle_on = 1'b1;
	bit       sink_idle_on = 1'b1;
	dir_row_t dir_rows [0:17];

	complex_fir_filter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		err_count++;
	endtask

	// Rounds half toward plus infinity, drops the fraction bits and clips to Q1.15.
	function automatic logic signed [15:0] round_q15(input longint acc, inout bit clip);
		longint r;
		r = (acc + 64'sd16384) >>> cfir_pkg::FRAC_W;
		if (r > 32767) begin
			clip = 1'b1;
			r = 32767;
		end else if (r < -32768) begin
			clip = 1'b1;
			r = -32768;
		end
		return r[15:0];
	endfunction

	// Applies one word to the predicted state; returns 1 when the word yields a filtered sample.
	function automatic bit model_word(input logic [1:0] mode, input logic [71:0] data,
			output fir_out_t res);
		shortint x_re;
		shortint x_im;
		shortint xr;
		shortint xi;
		longint  acc_re;
		longint  acc_im;
		int      n;
		int      d;
		bit      clip;
		res = '0;
		case (mode)
			cfir_pkg::MODE_TAP: begin
				coef_re[data[37:32]] = data[53:38];
				coef_im[data[37:32]] = data[69:54];
				return 1'b0;
			end
			cfir_pkg::MODE_CLEAR: begin
				for (int i = 0; i < cfir_pkg::MAX_TAPS - 1; i++) begin
					hist_re[i] = 0;
					hist_im[i] = 0;
				end
				return 1'b0;
			end
			cfir_pkg::MODE_FILTER: begin
				x_re = data[15:0];
				x_im = data[31:16];
				n = (tap_count == 0) ? 1 : ((tap_count > cfir_pkg::MAX_TAPS) ?
					cfir_pkg::MAX_TAPS : tap_count);
				acc_re = 0;
				acc_im = 0;
				clip = 1'b0;
				for (int k = 0; k < n; k++) begin
					d = n - 1 - k;
					xr = (d == 0) ? x_re : hist_re[d-1];
					xi = (d == 0) ? x_im : hist_im[d-1];
					acc_re += longint'(xr) * longint'(coef_re[k]) - longint'(xi) * longint'(coef_im[k]);
					acc_im += longint'(xr) * longint'(coef_im[k]) + longint'(xi) * longint'(coef_re[k]);
				end
				for (int i = cfir_pkg::MAX_TAPS - 2; i > 0; i--) begin
					hist_re[i] = hist_re[i-1];
					hist_im[i] = hist_im[i-1];
				end
				hist_re[0] = x_re;
				hist_im[0] = x_im;
				res.re = round_q15(acc_re, clip);
				res.im = round_q15(acc_im, clip);
				res.sat = clip;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [71:0] pack_word(input logic [15:0] s_re, input logic [15:0] s_im,
			input logic [5:0] t_idx, input logic [15:0] t_re, input logic [15:0] t_im);
		return {2'b00, t_im, t_re, t_idx, s_im, s_re};
	endfunction

	function automatic logic [15:0] rand_q15();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return r[15:0] & 16'h000F ^ 16'hFFF8;
			default: return r[15:0];
		endcase
	endfunction

	// Taps are often scaled down so that sums over many taps do not always clip.
	function automatic logic [15:0] rand_tap();
		logic signed [15:0] v;
		v = rand_q15();
		return v >>> $urandom_range(6);
	endfunction

	// Called at a falling edge; returns at the falling edge after the word was taken.
	task automatic send_word(input logic [1:0] mode, input logic [71:0] data, input bit typed,
			input fir_out_t typed_res);
		fir_out_t res;
		while (src_idle_on && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= data;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		if (model_word(mode, data, res))
			fir_expected.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	// Tap writes and clears give no word back, so the block gets time to finish after the last one.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (fir_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_num_taps(input logic [6:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		tap_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, plus one long hold-off on request from the stimulus.
	initial begin
		int hold_served;
		int hold_left;
		hold_served = 0;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ticket != hold_served) begin
				hold_served = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(sink_idle_on && $urandom_range(99) < 10);
			end
		end
	end

	always @(posedge clk) begin : check_results
		fir_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (fir_expected.size() == 0) begin
				report_mismatch("word with nothing expected, out_re", $signed(m_tdata[15:0]), 0);
			end else begin
				want = fir_expected.pop_front();
				if (m_tdata[15:0] !== want.re)
					report_mismatch("out_re", $signed(m_tdata[15:0]), want.re);
				if (m_tdata[31:16] !== want.im)
					report_mismatch("out_im", $signed(m_tdata[31:16]), want.im);
				if (m_tuser !== want.sat)
					report_mismatch("saturated", m_tuser, want.sat);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** complex_fir_filter_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		fir_out_t typed_res;
		int       n_eff;
		int       r;
		int       idx;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = cfir_pkg::MODE_FILTER;
		cfg_valid = 1'b0;
		cfg_data = '0;
		for (int i = 0; i < cfir_pkg::MAX_TAPS; i++) begin
			coef_re[i] = 0;
			coef_im[i] = 0;
			if (i < cfir_pkg::MAX_TAPS - 1) begin
				hist_re[i] = 0;
				hist_im[i] = 0;
			end
		end
		tap_count = 1;

		// One tap in use; values go to both the sample and the tap fields of the word.
		dir_rows = '{
			'{cfir_pkg::MODE_FILTER, 32767, -32768, 0, 1, 0, 0, 0},
			'{cfir_pkg::MODE_TAP, -32768, 0, 0, 0, 0, 0, 0},
			'{cfir_pkg::MODE_FILTER, -32768, -32768, 0, 1, 32767, 32767, 1},
			'{cfir_pkg::MODE_FILTER, 32767, 32767, 0, 0, 0, 0, 0},
			'{cfir_pkg::MODE_TAP, 32767, 32767, 0, 0, 0, 0, 0},
			'{cfir_pkg::MODE_FILTER, 32767, -32768, 0, 0, 0, 0, 0},
			'{cfir_pkg::MODE_TAP, 32767, -32768, 0, 0, 0, 0, 0},
			'{cfir_pkg::MODE_FILTER, -32768, -32768, 0, 1, -32768, 1, 1},
			'{cfir_pkg::MODE_TAP, 0, -32768, 0, 0, 0, 0, 0},
			'{cfir_pkg::MODE_FILTER, 0, 16384, 0, 1, 16384, 0, 0},
			'{cfir_pkg::MODE_TAP, 16384, 0, 0, 0, 0, 0, 0},
			'{cfir_pkg::MODE_FILTER, 1, -1, 0, 1, 1, 0, 0},
			'{cfir_pkg::MODE_FILTER, -1, 1, 0, 1, 0, 1, 0},
			'{cfir_pkg::MODE_TAP, 32767, -32768, 63, 0, 0, 0, 0},
			'{cfir_pkg::MODE_TAP, -1, 1, 42, 0, 0, 0, 0},
			'{MODE_UNUSED, -1, -1, 63, 0, 0, 0, 0},
			'{cfir_pkg::MODE_CLEAR, -1, -1, 63, 0, 0, 0, 0},
			'{cfir_pkg::MODE_FILTER, 12345, -23456, 0, 0, 0, 0, 0}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			typed_res.re = 16'(dir_rows[i].e_re);
			typed_res.im = 16'(dir_rows[i].e_im);
			typed_res.sat = dir_rows[i].e_sat;
			send_word(dir_rows[i].mode,
				pack_word(16'(dir_rows[i].re), 16'(dir_rows[i].im), 6'(dir_rows[i].idx),
					16'(dir_rows[i].re), 16'(dir_rows[i].im)),
				dir_rows[i].typed, typed_res);
		end

		// History is not cleared between settings, so a new tap count sees the real past samples.
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_num_taps(7'(PHASE_TAPS[p]));
			n_eff = (PHASE_TAPS[p] == 0) ? 1 : ((PHASE_TAPS[p] > cfir_pkg::MAX_TAPS) ?
				cfir_pkg::MAX_TAPS : PHASE_TAPS[p]);
			src_idle_on = (p != 3);
			sink_idle_on = (p != 3);
			if (p == 1)
				hold_ticket <= hold_ticket + 1;
			for (int k = 0; k < n_eff; k++)
				send_word(cfir_pkg::MODE_TAP,
					pack_word(rand_q15(), rand_q15(), 6'(k), rand_tap(), rand_tap()),
					1'b0, '0);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (p == 7 && i == PHASE_WORDS / 2)
					drain_results();
				r = $urandom_range(99);
				if (r < 70) begin
					send_word(cfir_pkg::MODE_FILTER,
						pack_word(rand_q15(), rand_q15(), 6'($urandom_range(63)),
							rand_q15(), rand_q15()),
						1'b0, '0);
				end else if (r < 90) begin
					idx = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(n_eff - 1);
					send_word(cfir_pkg::MODE_TAP,
						pack_word(rand_q15(), rand_q15(), 6'(idx), rand_tap(), rand_tap()),
						1'b0, '0);
				end else if (r < 95) begin
					send_word(cfir_pkg::MODE_CLEAR,
						pack_word(rand_q15(), rand_q15(), 6'($urandom_range(63)),
							rand_q15(), rand_q15()),
						1'b0, '0);
				end else begin
					send_word(MODE_UNUSED,
						pack_word(rand_q15(), rand_q15(), 6'($urandom_range(63)),
							rand_q15(), rand_q15()),
						1'b0, '0);
				end
			end
		end

		drain_results();
		if (err_count == 0)
			$display("** complex_fir_filter_unit: PASSED **");
		else
			$display("** complex_fir_filter_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cfir_pkg.sv
rtl/cfir_store.sv
rtl/cfir_mac.sv
rtl/complex_fir_filter_unit.sv
bench/testbench.sv
